[sv/line_delimited_byte_framer_defines.svh]
// Assertion macros shared by the framer modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LINE_DELIMITED_BYTE_FRAMER_DEFINES_SVH
`define LINE_DELIMITED_BYTE_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define LDBF_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LDBF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`else

`define LDBF_ASSERT_IMPLY(label, ante, cons)
`define LDBF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/ldbf_pkg.sv]
`default_nettype none

package ldbf_pkg;

	// Width of the frame length field of a result.
	localparam int unsigned LEN_W = 5;

	// Line terminators.
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Reset value of the idle timeout register.
	localparam logic [7:0] TIMEOUT_RESET = 8'd3;

	// Operation codes of an input request.
	localparam logic OP_BYTE = 1'b0;

	// Register indexes.
	localparam logic REG_IDLE_TIMEOUT = 1'b0;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       rx_error;
	} item_t;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic             frame_last;
		logic [LEN_W-1:0] frame_length;
	} frame_t;

	// Status of the readout engine seen by the front end.
	typedef struct packed {
		logic reading;
	} emit_stat_t;

endpackage

`default_nettype wire

[sv/line_delimited_byte_framer.sv]
// Line-delimited byte framer. Each request on the item channel is either a received UART
// byte with its line-error flag or an idle tick. Error-free bytes are stored in an on-chip
// frame store of FRAME_MAX bytes; a CR or LF byte, a full store, or idle_timeout_ticks ticks
// seen with a partial frame pending sends the frame out on the frame channel, one byte per
// request, with frame_last on the final byte and the frame length on every byte. Bytes that
// carry a line error are dropped, and ticks with an empty store do nothing. A request that
// ends a frame holds off new requests while the store is read out through its single read
// port, one byte per cycle while the frame channel is not stalled; each fetched byte waits
// in the RAM output register until the output register takes it. The idle timeout register
// sits at byte address 0 of the APB port and resets to 3; it should only be written while
// the block is idle.
`default_nettype none

`include "line_delimited_byte_framer_defines.svh"

module line_delimited_byte_framer #(
	parameter int unsigned FRAME_MAX = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// Input requests.
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire ldbf_pkg::item_t item,
	// Output requests.
	output logic               frame_valid,
	input  wire logic          frame_stall,
	output ldbf_pkg::frame_t   frame,
	// Configuration port.
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready
);

	import ldbf_pkg::*;

	localparam int unsigned AW = $clog2(FRAME_MAX);
	localparam int unsigned CW = $clog2(FRAME_MAX + 1);

	// Front-end state: number of bytes held and idle ticks seen since the last byte.
	logic [CW-1:0] fill_q;
	logic [7:0]    idle_q;
	logic [7:0]    timeout_q;

	logic          item_acc;
	logic          is_byte;
	logic          byte_ok;
	logic [CW-1:0] fill_inc;
	logic [7:0]    idle_inc;
	logic          byte_ends;
	logic          tick_flush;
	logic          start;
	logic [CW-1:0] start_len;
	logic          cfg_wr;
	logic          cfg_hit;
	emit_stat_t    stat;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// New requests are held off only while a frame is still being read from the store.
	assign item_stall = stat.reading;
	assign item_acc   = item_valid && !item_stall;

	assign is_byte  = item.operation == OP_BYTE;
	assign byte_ok  = is_byte && !item.rx_error;
	assign fill_inc = fill_q + CW'(1);
	// The idle count saturates, although it can never climb past the timeout.
	assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

	// A stored byte ends the frame when it is a terminator or it fills the store.
	assign byte_ends = (item.data_byte == CHAR_CR) || (item.data_byte == CHAR_LF) ||
		(fill_inc == CW'(FRAME_MAX));
	// A tick with a pending frame flushes it once the raised count reaches the timeout; a
	// timeout of zero therefore flushes on the first such tick.
	assign tick_flush = !is_byte && (fill_q != '0) && (idle_inc >= timeout_q);

	assign start     = item_acc && ((byte_ok && byte_ends) || tick_flush);
	assign start_len = byte_ok ? fill_inc : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			idle_q    <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			// Handing a frame to the readout engine empties the store at once, since the
			// engine walks its own copy of the length.
			if (start) begin
				fill_q <= '0;
				idle_q <= '0;
			end else if (item_acc && byte_ok) begin
				fill_q <= fill_inc;
				idle_q <= '0;
			end else if (item_acc && !is_byte && (fill_q != '0)) begin
				idle_q <= idle_inc;
			end
			if (cfg_wr && cfg_hit) begin
				timeout_q <= pwdata[7:0];
			end
		end
	end

	// The configuration port has no wait states; addresses beyond the register read as zero.
	assign pready  = 1'b1;
	assign cfg_hit = paddr[2] == REG_IDLE_TIMEOUT;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = cfg_hit ? {24'd0, timeout_q} : 32'd0;

	// The frame store. A byte written in the cycle that ends its frame is read no earlier
	// than the next cycle, so the read never overlaps the write of the same entry.
	ldbf_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_MAX)
	) u_store (
		.clk   (clk),
		.we    (item_acc && byte_ok),
		.waddr (fill_q[AW-1:0]),
		.wdata (item.data_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ldbf_emit #(
		.FRAME_MAX(FRAME_MAX)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_len   (start_len),
		.stat        (stat),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

	`LDBF_ASSERT_IMPLY(a_fill_below_max, 1'b1, fill_q < CW'(FRAME_MAX))
	`LDBF_ASSERT_NEXT(a_start_reads, start, stat.reading && (fill_q == '0))
	`LDBF_ASSERT_IMPLY(a_idle_needs_frame, idle_q != '0, fill_q != '0)

endmodule

`default_nettype wire

[sv/ldbf_ram.sv]
`default_nettype none

module ldbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 20
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/ldbf_emit.sv]
`default_nettype none

`include "line_delimited_byte_framer_defines.svh"

module ldbf_emit #(
	parameter int unsigned FRAME_MAX = 20,
	localparam int unsigned AW = $clog2(FRAME_MAX),
	localparam int unsigned CW = $clog2(FRAME_MAX + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [CW-1:0]       start_len,
	output ldbf_pkg::emit_stat_t     stat,
	output logic                     rd_en,
	output logic      [AW-1:0]       rd_addr,
	input  wire logic [7:0]          rd_data,
	output logic                     frame_valid,
	input  wire logic                frame_stall,
	output ldbf_pkg::frame_t         frame
);

	import ldbf_pkg::*;

	logic             reading_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    len_q;
	logic             pend_q;
	logic             pend_last_q;
	logic [CW-1:0]    pend_len_q;
	logic             load;
	logic             rd_last;

	// The RAM output register holds a fetched byte until the output register takes it.
	assign load    = pend_q && (!frame_valid || !frame_stall);
	assign rd_en   = reading_q && (!pend_q || load);
	assign rd_addr = rd_ptr_q;
	assign rd_last = (CW'(rd_ptr_q) + CW'(1)) == len_q;
	assign stat.reading = reading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q   <= 1'b0;
			pend_q      <= 1'b0;
			frame_valid <= 1'b0;
			rd_ptr_q    <= '0;
		end else begin
			if (start) begin
				reading_q <= 1'b1;
				rd_ptr_q  <= '0;
			end else if (rd_en) begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
				if (rd_last) begin
					reading_q <= 1'b0;
				end
			end
			if (rd_en) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				frame_valid <= 1'b1;
			end else if (!frame_stall) begin
				frame_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			len_q <= start_len;
		end
		if (rd_en) begin
			pend_last_q <= rd_last;
			pend_len_q  <= len_q;
		end
		if (load) begin
			frame.frame_byte   <= rd_data;
			frame.frame_last   <= pend_last_q;
			frame.frame_length <= LEN_W'(pend_len_q);
		end
	end

	`LDBF_ASSERT_IMPLY(a_start_when_free, start, !reading_q)
	`LDBF_ASSERT_IMPLY(a_read_in_frame, rd_en, CW'(rd_ptr_q) < len_q)
	`LDBF_ASSERT_IMPLY(a_reading_nonempty, reading_q, len_q != '0)

endmodule

`default_nettype wire

[tb/line_delimited_byte_framer_checker.sv]
module line_delimited_byte_framer_checker #(
	parameter int unsigned FRAME_MAX         = 20,
	parameter logic [2:0]  IDLE_TIMEOUT_ADDR = 3'd0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  ldbf_pkg::item_t  item,
	input  logic             frame_valid,
	input  logic             frame_stall,
	input  ldbf_pkg::frame_t frame,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic             pready,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import ldbf_pkg::*;

	logic [7:0]  held_bytes [FRAME_MAX];
	int unsigned bytes_held;
	logic [7:0]  idle_ticks;
	logic [7:0]  timeout_ticks;
	frame_t      frame_bytes_due [$];
	int          mismatch_tally = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Moves the whole pending frame to the queue of bytes due out and empties the store.
	task automatic flush_frame();
		for (int k = 0; k < bytes_held; k++) begin
			frame_bytes_due.push_back('{
				frame_byte:   held_bytes[k],
				frame_last:   (k + 1 == bytes_held),
				frame_length: LEN_W'(bytes_held)
			});
		end
		bytes_held = 0;
		idle_ticks = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_t due;
		if (!arst_n) begin
			frame_bytes_due.delete();
			bytes_held = 0;
			idle_ticks = '0;
			timeout_ticks = TIMEOUT_RESET;
		end else begin
			if (frame_valid && !frame_stall) begin
				if (frame_bytes_due.size() == 0) begin
					mismatch_tally++;
					$display("%0t: unexpected frame byte: expected none, got %h %b %0d",
						$time, frame.frame_byte, frame.frame_last, frame.frame_length);
				end else begin
					due = frame_bytes_due.pop_front();
					if (frame.frame_byte !== due.frame_byte ||
							frame.frame_last !== due.frame_last ||
							frame.frame_length !== due.frame_length) begin
						mismatch_tally++;
						$display("%0t: frame mismatch: expected %h %b %0d, got %h %b %0d",
							$time, due.frame_byte, due.frame_last, due.frame_length,
							frame.frame_byte, frame.frame_last, frame.frame_length);
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == IDLE_TIMEOUT_ADDR)
				timeout_ticks = pwdata[7:0];
			if (item_valid && !item_stall) begin
				if (item.operation == OP_BYTE) begin
					if (!item.rx_error) begin
						held_bytes[bytes_held] = item.data_byte;
						bytes_held++;
						idle_ticks = '0;
						if (item.data_byte == CHAR_CR || item.data_byte == CHAR_LF ||
								bytes_held == FRAME_MAX)
							flush_frame();
					end
				end else if (bytes_held != 0) begin
					if (idle_ticks != 8'hFF)
						idle_ticks++;
					if (idle_ticks >= timeout_ticks)
						flush_frame();
				end
			end
		end
		mismatches <= mismatch_tally;
		pending <= frame_bytes_due.size();
	end

endmodule

[tb/line_delimited_byte_framer_test.sv]
module line_delimited_byte_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ldbf_pkg::*;

	localparam int unsigned FRAME_MAX         = 20;
	localparam logic [2:0]  IDLE_TIMEOUT_ADDR = 3'(4 * REG_IDLE_TIMEOUT);
	localparam logic        OP_TICK           = ~OP_BYTE;
	// A frame of FRAME_MAX bytes keeps the block busy while it is read out through the output
	// pipeline; these quiet cycles after the last byte leave it truly idle.
	localparam int          SETTLE_CYCLES     = FRAME_MAX + 10;

	typedef enum int { END_CR, END_LF, END_FULL, END_IDLE } frame_end_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        frame_valid;
	logic        frame_stall;
	frame_t      frame;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          pending;
	int          gap_pct = 20;
	int          stall_pct = 56;
	logic [7:0]  timeout_now = TIMEOUT_RESET;

	line_delimited_byte_framer #(
		.FRAME_MAX(FRAME_MAX)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame      (frame),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	line_delimited_byte_framer_checker #(
		.FRAME_MAX        (FRAME_MAX),
		.IDLE_TIMEOUT_ADDR(IDLE_TIMEOUT_ADDR)
	) checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame      (frame),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Should the block hang, this ends the run well after the slowest correct run would have.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// The receiver stalls the frame channel at random, once per cycle, at the current rate.
	initial begin
		frame_stall <= 1'b0;
		forever begin
			@(posedge clk);
			frame_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Offers one request on the item channel and returns once it has been taken. The valid is
	// only dropped when a gap is wanted, so back-to-back requests keep it high throughout.
	task automatic send_item(input logic op, input logic [7:0] data, input logic err);
		if ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < gap_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{operation: op, data_byte: data, rx_error: err};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Idle ticks carry random data and error flags, which the block must ignore.
	task automatic send_tick();
		send_item(OP_TICK, 8'($urandom), 1'($urandom));
	endtask

	// Waits until every predicted frame byte has come out, then lets the block settle so that
	// a register write cannot land on a request still in flight.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// One APB write of the idle timeout: a setup cycle, then an access cycle held until pready.
	// The upper data bits are random, as only the low byte belongs to the register.
	task automatic write_timeout(input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= IDLE_TIMEOUT_ADDR;
		pwdata <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		timeout_now = value;
	endtask

	// A well-formed frame with random content, closed in the chosen way. Errored bytes and
	// stray ticks are mixed in now and then; the checker follows whatever they do.
	task automatic send_frame(input frame_end_e ending);
		int         body;
		int         ticks;
		int         roll;
		logic [7:0] data;
		case (ending)
			END_FULL: body = FRAME_MAX;
			END_IDLE: body = $urandom_range(1, FRAME_MAX - 1);
			default:  body = $urandom_range(0, FRAME_MAX - 1);
		endcase
		for (int k = 0; k < body; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				send_item(OP_BYTE, 8'($urandom), 1'b1);
			else if (roll < 16)
				send_tick();
			data = 8'($urandom);
			// Terminators in the body would cut the frame short, so they are moved aside; the
			// top bit flip keeps every bit of the byte toggling.
			if (data == CHAR_CR || data == CHAR_LF)
				data ^= 8'h80;
			send_item(OP_BYTE, data, 1'b0);
		end
		case (ending)
			END_CR: send_item(OP_BYTE, CHAR_CR, 1'b0);
			END_LF: send_item(OP_BYTE, CHAR_LF, 1'b0);
			END_IDLE: begin
				ticks = (timeout_now == 0) ? 1 : timeout_now;
				repeat (ticks)
					send_tick();
			end
			default: ;
		endcase
	endtask

	initial begin
		logic [7:0] timeout_plan [6];
		timeout_plan = '{8'd2, 8'd7, 8'd1, 8'd0, TIMEOUT_RESET, 8'd0};
		timeout_plan[5] = 8'($urandom_range(2, 9));

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset timeout of three ticks.
		// A tick with nothing stored must do nothing at all.
		send_tick();
		// The byte extremes, an errored CR that must not end the frame, then an LF that does.
		send_item(OP_BYTE, 8'h00, 1'b0);
		send_item(OP_BYTE, 8'hFF, 1'b0);
		send_item(OP_BYTE, CHAR_CR, 1'b1);
		send_item(OP_BYTE, CHAR_LF, 1'b0);
		// An errored byte between ticks leaves the idle count alone, so the third tick flushes.
		send_item(OP_BYTE, 8'h41, 1'b0);
		send_tick();
		send_tick();
		send_item(OP_BYTE, CHAR_CR, 1'b1);
		send_tick();
		// A frame closed by CR.
		send_item(OP_BYTE, 8'h55, 1'b0);
		send_item(OP_BYTE, CHAR_CR, 1'b0);
		drain();
		// With a zero timeout the first tick over a pending frame flushes it.
		write_timeout(8'd0);
		send_item(OP_BYTE, 8'h7E, 1'b0);
		send_tick();
		drain();
		// A timeout of one behaves the same way.
		write_timeout(8'd1);
		send_item(OP_BYTE, 8'h81, 1'b0);
		send_tick();

		// Random frames over six timeout settings: the sender idles lightly and the receiver
		// heavily, then the other way round, then neither side holds back. Each pair of
		// settings sees every way of closing a frame.
		for (int p = 0; p < 6; p++) begin
			drain();
			if (p == 2) begin
				gap_pct = 56;
				stall_pct = 20;
			end else if (p == 4) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			write_timeout(timeout_plan[p]);
			for (int f = 0; f < 2; f++) begin
				if ($urandom_range(0, 9) == 0)
					send_tick();
				send_frame(frame_end_e'((p * 2 + f) % 4));
			end
		end
		drain();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
